// ===== rtl/sec_pkg.sv =====
`default_nettype none

package sec_pkg;

    // Item action codes
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_EVENT = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_READ_OPCODE    = 2'd0;
    localparam logic [1:0] CFG_WRITE_OPCODE   = 2'd1;
    localparam logic [1:0] CFG_COOLDOWN_TICKS = 2'd2;

    localparam logic [7:0] READ_OPCODE_RST    = 8'h03;
    localparam logic [7:0] WRITE_OPCODE_RST   = 8'h02;
    localparam logic [7:0] COOLDOWN_TICKS_RST = 8'd10;
    localparam logic [7:0] DUMMY_BYTE         = 8'h00;

    typedef enum logic [8:0] {
        PH_IDLE   = 9'b0_0000_0001,
        PH_WAIT   = 9'b0_0000_0010,
        PH_OPC    = 9'b0_0000_0100,
        PH_ADR_H  = 9'b0_0000_1000,
        PH_ADR_M  = 9'b0_0001_0000,
        PH_ADR_L  = 9'b0_0010_0000,
        PH_DATA_A = 9'b0_0100_0000,
        PH_DATA_B = 9'b0_1000_0000,
        PH_EXIT   = 9'b1_0000_0000
    } sec_phase_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [23:0] address;
        logic [15:0] length;
        logic        tx_empty;
        logic        rx_full;
        logic [7:0]  rx_data;
        logic [7:0]  write_data;
    } sec_in_t;

    typedef struct packed {
        logic       select_level;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       irq_enable;
        logic       busy_res;
    } sec_out_t;

    typedef struct packed {
        logic       we;
        logic [1:0] index;
        logic [7:0] data;
    } sec_cfg_wr_t;

endpackage

`default_nettype wire

// ===== rtl/spi_eeprom_command_sequencer.sv =====
// SPI EEPROM command sequencer.
// Requests enter on item_valid/item_ready: a read or write request (action 0/1)
// latches address and length, an SPI event (action 2) advances the transfer,
// a tick (action 3) counts down the cooldown after a transfer. Every request
// yields exactly one result on result_valid/result_ready: chip select level,
// the byte sent, the read byte delivered, interrupt enable and busy.
// Configuration (opcodes and cooldown length) is written on cfg_valid/
// cfg_ready, index 0 read opcode, 1 write opcode, 2 cooldown ticks; cfg_ready
// is always high and writes are meant for idle periods only.
// A request accepted into the input register has its result registered in the
// result register as soon as that has space. Throughput is one request per
// cycle while results drain: the sequencer state updates in a single pass of
// logic between the input register and the result register.
// Reset: phases idle, counters zero, select deselected (high), interrupt
// enable low, configuration back to 0x03 / 0x02 / 10, both stages empty.
// Stall: while result_ready is low a held result stays put; one more request
// waits in the input register, then item_ready drops until the result drains.
`default_nettype none

module spi_eeprom_command_sequencer
    import sec_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire sec_in_t    item,
    output logic            result_valid,
    input  wire logic       result_ready,
    output sec_out_t        result,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    logic        held_valid;
    sec_in_t     held_item;
    logic        out_space;
    logic        take;
    sec_out_t    result_next;
    sec_cfg_wr_t cfg_wr;

    // Advance one request whenever the result register can take its result
    assign take      = held_valid && out_space;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_wr.we    = cfg_valid;
        cfg_wr.index = cfg_index;
        cfg_wr.data  = cfg_data;
    end

    sec_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    sec_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (take),
        .item        (held_item),
        .cfg_wr      (cfg_wr),
        .result_next (result_next)
    );

    sec_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (take),
        .data_next    (result_next),
        .space        (out_space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // A request held in the input stage must not change while it waits
    a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid && !take |=> $stable(held_item))
        else $error("held request changed while stalled");

    // Bytes only move on the link while the device is selected
    a_tx_selected: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.tx_valid || result.rx_valid) |-> !result.select_level)
        else $error("byte moved with select high");

    // Idle byte lanes read as zero
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.tx_valid || (result.tx_byte == 8'd0))
                         && (result.rx_valid || (result.rx_byte == 8'd0)))
        else $error("byte lane not zero while idle");

    // A load only happens into a free result register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (!result_valid || result_ready))
        else $error("result overwritten before taken");

endmodule

`default_nettype wire

// ===== rtl/sec_in_stage.sv =====
`default_nettype none

module sec_in_stage
    import sec_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire sec_in_t item,
    input  wire logic    take,
    output logic         held_valid,
    output sec_in_t      held_item
);

    logic    valid_reg;
    logic    valid_next;
    sec_in_t item_reg;

    assign item_ready = !valid_reg || take;
    assign valid_next = item_ready ? item_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load a new request whenever the slot frees up
    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/sec_core.sv =====
`default_nettype none

module sec_core
    import sec_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire sec_in_t     item,
    input  wire sec_cfg_wr_t cfg_wr,
    output sec_out_t         result_next
);

    typedef struct packed {
        sec_phase_t phase;
        logic       select_low;
        logic       txv;
        logic [7:0] txb;
    } sec_hdr_t;

    logic [7:0]  read_opcode_reg, write_opcode_reg, cooldown_ticks_reg;
    sec_phase_t  read_phase_reg, read_phase_next;
    sec_phase_t  write_phase_reg, write_phase_next;
    logic [23:0] read_address_reg, read_address_next;
    logic [23:0] write_address_reg, write_address_next;
    logic [15:0] read_remaining_reg, read_remaining_next;
    logic [15:0] write_remaining_reg, write_remaining_next;
    logic [7:0]  cooldown_count_reg, cooldown_count_next;
    logic        select_reg, select_next;
    logic        irq_enable_reg, irq_enable_next;

    logic        busy_now;
    logic        txv, rxv;
    logic [7:0]  txb, rxb;
    logic [7:0]  cool_dec;
    logic        write_yields;
    sec_hdr_t    hdr;
    sec_phase_t  hdr_phase;
    logic [7:0]  hdr_opcode;
    logic [23:0] hdr_address;

    // Opcode and three address bytes, shared by both directions
    function automatic sec_hdr_t hdr_step(
        input sec_phase_t  ph,
        input logic [7:0]  opc,
        input logic [23:0] adr,
        input logic        txe
    );
        sec_hdr_t h;
        h.phase      = ph;
        h.select_low = 1'b0;
        h.txv        = 1'b0;
        h.txb        = DUMMY_BYTE;
        unique case (ph)
            PH_WAIT:
            begin
                h.select_low = 1'b1;
                h.phase      = PH_OPC;
            end
            PH_OPC:
            begin
                if (txe)
                begin
                    h.txv   = 1'b1;
                    h.txb   = opc;
                    h.phase = PH_ADR_H;
                end
            end
            PH_ADR_H:
            begin
                if (txe)
                begin
                    h.txv   = 1'b1;
                    h.txb   = adr[23:16];
                    h.phase = PH_ADR_M;
                end
            end
            PH_ADR_M:
            begin
                if (txe)
                begin
                    h.txv   = 1'b1;
                    h.txb   = adr[15:8];
                    h.phase = PH_ADR_L;
                end
            end
            PH_ADR_L:
            begin
                if (txe)
                begin
                    h.txv   = 1'b1;
                    h.txb   = adr[7:0];
                    h.phase = PH_DATA_A;
                end
            end
            default:
            begin
                h.phase = ph;
            end
        endcase
        return h;
    endfunction

    assign busy_now     = (read_phase_reg != PH_IDLE) || (write_phase_reg != PH_IDLE);
    assign cool_dec     = (cooldown_count_reg != 8'd0) ? cooldown_count_reg - 8'd1
                                                       : cooldown_count_reg;
    assign write_yields = ((write_phase_reg == PH_IDLE) || (write_phase_reg == PH_WAIT))
                          && (read_phase_reg != PH_IDLE);
    assign hdr_phase    = write_yields ? read_phase_reg : write_phase_reg;
    assign hdr_opcode   = write_yields ? read_opcode_reg : write_opcode_reg;
    assign hdr_address  = write_yields ? read_address_reg : write_address_reg;
    assign hdr          = hdr_step(hdr_phase, hdr_opcode, hdr_address, item.tx_empty);

    always_comb
    begin
        read_phase_next      = read_phase_reg;
        write_phase_next     = write_phase_reg;
        read_address_next    = read_address_reg;
        write_address_next   = write_address_reg;
        read_remaining_next  = read_remaining_reg;
        write_remaining_next = write_remaining_reg;
        cooldown_count_next  = cooldown_count_reg;
        select_next          = select_reg;
        irq_enable_next      = irq_enable_reg;
        txv                  = 1'b0;
        txb                  = DUMMY_BYTE;
        rxv                  = 1'b0;
        rxb                  = DUMMY_BYTE;

        unique case (item.action)
            ACT_READ:
            begin
                if (read_phase_reg == PH_IDLE)
                begin
                    read_address_next   = item.address;
                    read_remaining_next = item.length;
                    read_phase_next     = PH_WAIT;
                    irq_enable_next     = 1'b1;
                end
            end
            ACT_WRITE:
            begin
                if (write_phase_reg == PH_IDLE)
                begin
                    write_address_next   = item.address;
                    write_remaining_next = item.length;
                    write_phase_next     = PH_WAIT;
                    irq_enable_next      = 1'b1;
                end
            end
            ACT_EVENT:
            begin
                priority if (!busy_now || (cooldown_count_reg != 8'd0))
                begin
                    irq_enable_next = 1'b0;
                    select_next     = 1'b1;
                end
                else if (write_yields)
                begin
                    unique case (read_phase_reg)
                        PH_DATA_A:
                        begin
                            txv             = 1'b1;
                            read_phase_next = PH_DATA_B;
                        end
                        PH_DATA_B:
                        begin
                            if (item.rx_full)
                            begin
                                rxv = 1'b1;
                                rxb = item.rx_data;
                                if (read_remaining_reg <= 16'd1)
                                begin
                                    read_remaining_next = 16'd0;
                                    read_phase_next     = PH_EXIT;
                                end
                                else
                                begin
                                    read_remaining_next = read_remaining_reg - 16'd1;
                                    txv                 = 1'b1;
                                end
                            end
                        end
                        PH_EXIT:
                        begin
                            read_phase_next     = PH_IDLE;
                            cooldown_count_next = cooldown_ticks_reg;
                        end
                        PH_WAIT, PH_OPC, PH_ADR_H, PH_ADR_M, PH_ADR_L:
                        begin
                            read_phase_next = hdr.phase;
                            txv             = hdr.txv;
                            txb             = hdr.txb;
                            if (hdr.select_low)
                            begin
                                select_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            read_phase_next = PH_IDLE;
                        end
                    endcase
                end
                else
                begin
                    unique case (write_phase_reg)
                        PH_DATA_A:
                        begin
                            if (item.tx_empty)
                            begin
                                txv = 1'b1;
                                txb = item.write_data;
                                if (write_remaining_reg <= 16'd1)
                                begin
                                    write_remaining_next = 16'd0;
                                    write_phase_next     = PH_EXIT;
                                end
                                else
                                begin
                                    write_remaining_next = write_remaining_reg - 16'd1;
                                end
                            end
                        end
                        PH_EXIT:
                        begin
                            write_phase_next    = PH_IDLE;
                            cooldown_count_next = cooldown_ticks_reg;
                        end
                        PH_WAIT, PH_OPC, PH_ADR_H, PH_ADR_M, PH_ADR_L:
                        begin
                            write_phase_next = hdr.phase;
                            txv              = hdr.txv;
                            txb              = hdr.txb;
                            if (hdr.select_low)
                            begin
                                select_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            write_phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            ACT_TICK:
            begin
                cooldown_count_next = cool_dec;
                if ((cool_dec == 8'd0) && busy_now)
                begin
                    irq_enable_next = 1'b1;
                end
            end
            default:
            begin
                irq_enable_next = irq_enable_reg;
            end
        endcase
    end

    always_comb
    begin
        result_next.select_level = select_next;
        result_next.tx_valid     = txv;
        result_next.tx_byte      = txv ? txb : DUMMY_BYTE;
        result_next.rx_valid     = rxv;
        result_next.rx_byte      = rxv ? rxb : DUMMY_BYTE;
        result_next.irq_enable   = irq_enable_next;
        result_next.busy_res     = (read_phase_next != PH_IDLE)
                                   || (write_phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_opcode_reg    <= READ_OPCODE_RST;
            write_opcode_reg   <= WRITE_OPCODE_RST;
            cooldown_ticks_reg <= COOLDOWN_TICKS_RST;
        end
        else if (cfg_wr.we)
        begin
            unique case (cfg_wr.index)
                CFG_READ_OPCODE:    read_opcode_reg    <= cfg_wr.data;
                CFG_WRITE_OPCODE:   write_opcode_reg   <= cfg_wr.data;
                CFG_COOLDOWN_TICKS: cooldown_ticks_reg <= cfg_wr.data;
                default:            read_opcode_reg    <= read_opcode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_phase_reg      <= PH_IDLE;
            write_phase_reg     <= PH_IDLE;
            read_address_reg    <= 24'd0;
            write_address_reg   <= 24'd0;
            read_remaining_reg  <= 16'd0;
            write_remaining_reg <= 16'd0;
            cooldown_count_reg  <= 8'd0;
            select_reg          <= 1'b1;
            irq_enable_reg      <= 1'b0;
        end
        else if (step)
        begin
            read_phase_reg      <= read_phase_next;
            write_phase_reg     <= write_phase_next;
            read_address_reg    <= read_address_next;
            write_address_reg   <= write_address_next;
            read_remaining_reg  <= read_remaining_next;
            write_remaining_reg <= write_remaining_next;
            cooldown_count_reg  <= cooldown_count_next;
            select_reg          <= select_next;
            irq_enable_reg      <= irq_enable_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sec_out_stage.sv =====
`default_nettype none

module sec_out_stage
    import sec_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  wire sec_out_t data_next,
    output logic          space,
    output logic          result_valid,
    input  wire logic     result_ready,
    output sec_out_t      result
);

    logic     valid_reg;
    logic     valid_next;
    sec_out_t data_reg;

    assign space      = !valid_reg || result_ready;
    assign valid_next = load || (valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

`default_nettype wire

// ===== test/tb_spi_eeprom_command_sequencer.sv =====
`timescale 1ns / 100ps

module tb_spi_eeprom_command_sequencer;
    import sec_pkg::*;

    // Cycles without any accepted request, result or register write before giving up.
    localparam int unsigned STALL_LIMIT = 4000;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    sec_in_t     item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    sec_out_t    result;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index    = CFG_READ_OPCODE;
    logic [7:0]  cfg_data     = '0;

    // Requests waiting for the driver, and bus status still owed by the block.
    sec_in_t     request_q[$];
    sec_out_t    expected_status[$];
    sec_out_t    want_status;

    int unsigned send_idle_pct = 9;
    int unsigned recv_idle_pct = 86;
    int unsigned queued        = 0;
    int unsigned mismatches    = 0;
    int unsigned stall_cycles  = 0;

    // Shadow copy of the sequencer: transfer phases, latched requests, cooldown,
    // chip select and interrupt enable, plus the three registers.
    sec_phase_t  rd_ph      = PH_IDLE;
    sec_phase_t  wr_ph      = PH_IDLE;
    logic [23:0] rd_adr     = '0;
    logic [23:0] wr_adr     = '0;
    logic [15:0] rd_left    = '0;
    logic [15:0] wr_left    = '0;
    logic [7:0]  cool_cnt   = '0;
    logic        sel_q      = 1'b1;
    logic        irq_q      = 1'b0;
    logic [7:0]  rd_opc     = READ_OPCODE_RST;
    logic [7:0]  wr_opc     = WRITE_OPCODE_RST;
    logic [7:0]  cool_ticks = COOLDOWN_TICKS_RST;

    spi_eeprom_command_sequencer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic seq_busy();
        return rd_ph != PH_IDLE || wr_ph != PH_IDLE;
    endfunction

    // Walk the opcode and address bytes shared by reads and writes.
    // Pull select low on the first event, then send one byte per event with tx_empty.
    function automatic logic send_header(inout sec_phase_t ph, input logic [7:0] opc,
                                         input logic [23:0] adr, input logic txe,
                                         output logic [7:0] b);
        b = 8'h00;
        case (ph)
            PH_WAIT:
            begin
                sel_q = 1'b0;
                ph    = PH_OPC;
            end
            PH_OPC:
            begin
                if (txe)
                begin
                    b  = opc;
                    ph = PH_ADR_H;
                    return 1'b1;
                end
            end
            PH_ADR_H:
            begin
                if (txe)
                begin
                    b  = adr[23:16];
                    ph = PH_ADR_M;
                    return 1'b1;
                end
            end
            PH_ADR_M:
            begin
                if (txe)
                begin
                    b  = adr[15:8];
                    ph = PH_ADR_L;
                    return 1'b1;
                end
            end
            PH_ADR_L:
            begin
                if (txe)
                begin
                    b  = adr[7:0];
                    ph = PH_DATA_A;
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Advance the shadow sequencer by one request and return the bus status it owes.
    function automatic sec_out_t sequencer_step(sec_in_t it);
        sec_out_t   o;
        logic       txv;
        logic       rxv;
        logic [7:0] txb;
        logic [7:0] rxb;
        txv = 1'b0;
        rxv = 1'b0;
        txb = 8'h00;
        rxb = 8'h00;
        case (it.action)
            ACT_READ:
            begin
                if (rd_ph == PH_IDLE)
                begin
                    rd_adr  = it.address;
                    rd_left = it.length;
                    rd_ph   = PH_WAIT;
                    irq_q   = 1'b1;
                end
            end
            ACT_WRITE:
            begin
                if (wr_ph == PH_IDLE)
                begin
                    wr_adr  = it.address;
                    wr_left = it.length;
                    wr_ph   = PH_WAIT;
                    irq_q   = 1'b1;
                end
            end
            ACT_EVENT:
            begin
                if (!seq_busy() || cool_cnt != 8'd0)
                begin
                    // Nothing to do or still cooling: deselect and mask interrupts.
                    irq_q = 1'b0;
                    sel_q = 1'b1;
                end
                else if ((wr_ph == PH_IDLE || wr_ph == PH_WAIT) && rd_ph != PH_IDLE)
                begin
                    // Read side: it also overtakes a write that has not started.
                    case (rd_ph)
                        PH_DATA_A:
                        begin
                            txv   = 1'b1;
                            txb   = DUMMY_BYTE;
                            rd_ph = PH_DATA_B;
                        end
                        PH_DATA_B:
                        begin
                            if (it.rx_full)
                            begin
                                rxv = 1'b1;
                                rxb = it.rx_data;
                                if (rd_left <= 16'd1)
                                begin
                                    rd_left = '0;
                                    rd_ph   = PH_EXIT;
                                end
                                else
                                begin
                                    rd_left = rd_left - 16'd1;
                                    txv     = 1'b1;
                                    txb     = DUMMY_BYTE;
                                end
                            end
                        end
                        PH_EXIT:
                        begin
                            rd_ph    = PH_IDLE;
                            cool_cnt = cool_ticks;
                        end
                        default: txv = send_header(rd_ph, rd_opc, rd_adr, it.tx_empty, txb);
                    endcase
                end
                else
                begin
                    case (wr_ph)
                        PH_DATA_A:
                        begin
                            if (it.tx_empty)
                            begin
                                txv = 1'b1;
                                txb = it.write_data;
                                if (wr_left <= 16'd1)
                                begin
                                    wr_left = '0;
                                    wr_ph   = PH_EXIT;
                                end
                                else
                                begin
                                    wr_left = wr_left - 16'd1;
                                end
                            end
                        end
                        PH_EXIT:
                        begin
                            wr_ph    = PH_IDLE;
                            cool_cnt = cool_ticks;
                        end
                        default: txv = send_header(wr_ph, wr_opc, wr_adr, it.tx_empty, txb);
                    endcase
                end
            end
            default:
            begin
                // Tick: count the cooldown down and re-arm interrupts once it runs out.
                if (cool_cnt != 8'd0)
                    cool_cnt = cool_cnt - 8'd1;
                if (cool_cnt == 8'd0 && seq_busy())
                    irq_q = 1'b1;
            end
        endcase
        o.select_level = sel_q;
        o.tx_valid     = txv;
        o.tx_byte      = txv ? txb : 8'h00;
        o.rx_valid     = rxv;
        o.rx_byte      = rxv ? rxb : 8'h00;
        o.irq_enable   = irq_q;
        o.busy_res     = seq_busy();
        return o;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic push_item(logic [1:0] act, logic [23:0] adr, logic [15:0] len,
                             logic txe, logic rxf, logic [7:0] rxd, logic [7:0] wrd);
        sec_in_t r;
        r.action     = act;
        r.address    = adr;
        r.length     = len;
        r.tx_empty   = txe;
        r.rx_full    = rxf;
        r.rx_data    = rxd;
        r.write_data = wrd;
        request_q.push_back(r);
        queued++;
    endtask

    // Queue a request with random content; good_pct sets how often tx_empty and
    // rx_full are high.
    task automatic push_beat(logic [1:0] act, int unsigned good_pct);
        push_item(act, 24'($urandom_range(0, 24'hFF_FFFF)), 16'($urandom_range(0, 16'hFFFF)),
                  $urandom_range(0, 99) < good_pct, $urandom_range(0, 99) < good_pct,
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic push_request(logic [1:0] act, logic [15:0] len);
        push_item(act, 24'($urandom_range(0, 24'hFF_FFFF)), len, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    // Mostly SPI events, with the odd tick mixed in.
    task automatic push_traffic(int unsigned n, int unsigned good_pct);
        int unsigned i;
        for (i = 0; i < n; i++)
            push_beat(($urandom_range(0, 9) == 0) ? ACT_TICK : ACT_EVENT, good_pct);
    endtask

    // Tick out the cooldown; now and then poke a couple of events in while cooling.
    task automatic push_cooldown(int unsigned cool);
        int unsigned i;
        int unsigned early;
        early = ($urandom_range(0, 3) == 0) ? cool / 2 : cool + $urandom_range(0, 2);
        for (i = 0; i < early; i++)
            push_beat(ACT_TICK, 50);
        if (early < cool)
        begin
            push_beat(ACT_EVENT, 80);
            push_beat(ACT_EVENT, 80);
            for (i = early; i <= cool; i++)
                push_beat(ACT_TICK, 50);
        end
    endtask

    // One well-formed transfer, or a write followed by a read, either straight after it or once the write is under way.
    task automatic run_burst(int unsigned cool);
        int unsigned mode;
        int unsigned rd_len;
        int unsigned wr_len;
        int unsigned budget;
        mode   = $urandom_range(0, 3);
        rd_len = $urandom_range(0, 6);
        wr_len = $urandom_range(0, 6);
        budget = ((rd_len > wr_len ? rd_len : wr_len) + 8) * 3 / 2 + 2;
        if (mode != 0)
            push_request(ACT_WRITE, 16'(wr_len));
        if (mode == 0 || mode == 2)
            push_request(ACT_READ, 16'(rd_len));
        // Same kind already pending: this one must be dropped.
        if ($urandom_range(0, 3) == 0)
            push_beat((mode == 0) ? ACT_READ : ACT_WRITE, 50);
        if (mode == 3)
        begin
            // Let the write get going before the read turns up.
            push_traffic(3, 80);
            push_request(ACT_READ, 16'(rd_len));
        end
        push_traffic(budget, 80);
        push_cooldown(cool);
        if (mode >= 2)
        begin
            push_traffic(budget, 80);
            push_cooldown(cool);
        end
    endtask

    task automatic run_random(int unsigned count, int unsigned cool);
        int unsigned target;
        target = queued + count;
        while (queued < target)
        begin
            if ($urandom_range(0, 9) == 0)
                push_beat(2'($urandom_range(ACT_EVENT, ACT_TICK)), 50);
            else
                run_burst(cool);
        end
    endtask

    // Hold until every request went in and every status came back, then settle.
    task automatic wait_drained();
        while (request_q.size() != 0 || item_valid || expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Keep valid up across a series of writes; the caller drops it afterwards.
    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_READ_OPCODE:  rd_opc     = val;
            CFG_WRITE_OPCODE: wr_opc     = val;
            default:          cool_ticks = val;
        endcase
    endtask

    task automatic set_config(logic [7:0] rd_op, logic [7:0] wr_op, logic [7:0] cool);
        write_reg(CFG_READ_OPCODE, rd_op);
        write_reg(CFG_WRITE_OPCODE, wr_op);
        write_reg(CFG_COOLDOWN_TICKS, cool);
        cfg_valid <= 1'b0;
    endtask

    // Driver: present the next queued request, predict its status once it is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
                expected_status.push_back(sequencer_step(item));
            if (!item_valid || item_ready)
            begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item       <= request_q.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each status against the oldest prediction, field by field.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_status.size() == 0)
                begin
                    report_mismatch("status arrived with nothing expected");
                end
                else
                begin
                    want_status = expected_status.pop_front();
                    if (result.select_level !== want_status.select_level)
                        report_mismatch($sformatf("select_level got %0h expected %0h",
                                                  result.select_level, want_status.select_level));
                    if (result.tx_valid !== want_status.tx_valid)
                        report_mismatch($sformatf("tx_valid got %0h expected %0h",
                                                  result.tx_valid, want_status.tx_valid));
                    if (result.tx_byte !== want_status.tx_byte)
                        report_mismatch($sformatf("tx_byte got %0h expected %0h",
                                                  result.tx_byte, want_status.tx_byte));
                    if (result.rx_valid !== want_status.rx_valid)
                        report_mismatch($sformatf("rx_valid got %0h expected %0h",
                                                  result.rx_valid, want_status.rx_valid));
                    if (result.rx_byte !== want_status.rx_byte)
                        report_mismatch($sformatf("rx_byte got %0h expected %0h",
                                                  result.rx_byte, want_status.rx_byte));
                    if (result.irq_enable !== want_status.irq_enable)
                        report_mismatch($sformatf("irq_enable got %0h expected %0h",
                                                  result.irq_enable, want_status.irq_enable));
                    if (result.busy_res !== want_status.busy_res)
                        report_mismatch($sformatf("busy_res got %0h expected %0h",
                                                  result.busy_res, want_status.busy_res));
                end
            end
            result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned cool;
        int unsigned i;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short cooldown so the directed walk stays compact.
        set_config(READ_OPCODE_RST, WRITE_OPCODE_RST, 8'd1);

        // Event and tick with nothing to do.
        push_item(ACT_EVENT, 24'h00_0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00);
        push_item(ACT_TICK,  24'hFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 8'hFF, 8'hFF);
        // Zero-length write waits, a read overtakes it, a second read is dropped.
        push_item(ACT_WRITE, 24'hFF_FFFF, 16'h0000, 1'b1, 1'b1, 8'hFF, 8'hFF);
        push_item(ACT_READ,  24'h00_0000, 16'h0001, 1'b0, 1'b0, 8'h00, 8'h00);
        push_item(ACT_READ,  24'hAB_CDEF, 16'hFFFF, 1'b1, 1'b1, 8'h5A, 8'hA5);
        // Select, then opcode and address with one stall on tx_empty.
        push_item(ACT_EVENT, 24'h00_0000, 16'h0000, 1'b1, 1'b0, 8'h00, 8'h00);
        push_item(ACT_EVENT, 24'h00_0000, 16'h0000, 1'b0, 1'b1, 8'h00, 8'h00);
        for (i = 0; i < 4; i++)
            push_item(ACT_EVENT, 24'h00_0000, 16'h0000, 1'b1, 1'b0, 8'h00, 8'h00);
        // Dummy byte goes out regardless of tx_empty; data waits for rx_full.
        push_item(ACT_EVENT, 24'h00_0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00);
        push_item(ACT_EVENT, 24'h00_0000, 16'h0000, 1'b1, 1'b0, 8'hFF, 8'h00);
        push_item(ACT_EVENT, 24'h00_0000, 16'h0000, 1'b0, 1'b1, 8'hFF, 8'h00);
        // Close the read, hit it while cooling, then let the tick re-arm interrupts.
        push_item(ACT_EVENT, 24'h00_0000, 16'h0000, 1'b1, 1'b1, 8'h00, 8'h00);
        push_item(ACT_EVENT, 24'h00_0000, 16'h0000, 1'b1, 1'b1, 8'h00, 8'h00);
        push_item(ACT_TICK,  24'h00_0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00);
        // The waiting write runs now; its only data byte stalls once on tx_empty.
        for (i = 0; i < 5; i++)
            push_item(ACT_EVENT, 24'h00_0000, 16'h0000, 1'b1, 1'b1, 8'h00, 8'h00);
        push_item(ACT_EVENT, 24'h00_0000, 16'h0000, 1'b0, 1'b1, 8'h00, 8'hFF);
        push_item(ACT_EVENT, 24'h00_0000, 16'h0000, 1'b1, 1'b0, 8'h00, 8'h00);
        push_item(ACT_EVENT, 24'h00_0000, 16'h0000, 1'b1, 1'b1, 8'h00, 8'h00);
        push_item(ACT_TICK,  24'h00_0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00);
        push_item(ACT_EVENT, 24'h00_0000, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00);
        wait_drained();

        // Power-on values, with a busy sender and a stalling receiver.
        set_config(READ_OPCODE_RST, WRITE_OPCODE_RST, COOLDOWN_TICKS_RST);
        run_random(120, COOLDOWN_TICKS_RST);
        wait_drained();

        // Extremes with no cooldown; swap the idling sides.
        send_idle_pct = 86;
        recv_idle_pct = 9;
        set_config(8'hFF, 8'h00, 8'h00);
        run_random(120, 0);
        wait_drained();

        // Longest cooldown: one short write, then tick it all out; no idling from here on.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(8'h00, 8'hFF, 8'hFF);
        push_request(ACT_WRITE, 16'd2);
        push_traffic(16, 90);
        push_cooldown(255);
        wait_drained();

        // Random opcodes, short cooldown, then the start of a read of the largest length.
        cool = $urandom_range(1, 4);
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'(cool));
        run_random(120, cool);
        push_request(ACT_READ, 16'hFFFF);
        for (i = 0; i < 60; i++)
            push_beat(ACT_EVENT, 98);
        push_traffic(20, 80);
        wait_drained();

        if (mismatches == 0 && expected_status.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
